### design/lprl_pkg.sv
// Shared types, codes and helpers for the longest-prefix route lookup unit.
// No dependencies; used by lprl_cell and longest_prefix_route_lookup_unit.
`timescale 1ns / 1ps

package lprl_pkg;

  localparam int ADDR_BITS  = 32;
  localparam int LEN_BITS   = 6;
  localparam int IFACE_BITS = 4;

  typedef enum logic {
    KIND_ADD    = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_HIT   = 2'd2,
    ST_MISS  = 2'd3
  } status_t;

  // Request travelling down the chain. For an add, key/len/iface/has_hop/hop
  // carry the route and done marks it placed. For a lookup, key is the
  // destination and len/iface/has_hop/hop carry the best route so far.
  typedef struct packed {
    logic                  valid;
    kind_t                 kind;
    logic                  done;
    logic [ADDR_BITS-1:0]  key;
    logic [LEN_BITS-1:0]   len;
    logic [IFACE_BITS-1:0] iface;
    logic                  has_hop;
    logic [ADDR_BITS-1:0]  hop;
  } token_t;

  // Leading-ones mask of the given prefix length; lengths above 32 saturate.
  function automatic logic [ADDR_BITS-1:0] len_mask(input logic [LEN_BITS-1:0] len);
    logic [ADDR_BITS-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= LEN_BITS'(ADDR_BITS)) begin
      m = '1;
    end else begin
      m = {ADDR_BITS{1'b1}} << (LEN_BITS'(ADDR_BITS) - len);
    end
    return m;
  endfunction

endpackage

### design/lprl_cell.sv
// One route table slot with its compare logic, one link of the lookup chain.
// Depends on lprl_pkg for the request type and the prefix mask function.
`timescale 1ns / 1ps

module lprl_cell (
  input  logic            clk,
  input  logic            rst,
  input  lprl_pkg::token_t tok_in,
  output lprl_pkg::token_t tok_out
);

  logic                            valid;
  logic [lprl_pkg::ADDR_BITS-1:0]  prefix;
  logic [lprl_pkg::LEN_BITS-1:0]   length;
  logic [lprl_pkg::IFACE_BITS-1:0] iface;
  logic                            has_hop;
  logic [lprl_pkg::ADDR_BITS-1:0]  hop;

  logic             take_add;
  logic             take_lookup;
  lprl_pkg::token_t tok_next;

  // Slots fill from the bottom and are never freed, so the first free slot
  // lies past every valid one: claim it, or overwrite an equal route.
  assign take_add = tok_in.valid && (tok_in.kind == lprl_pkg::KIND_ADD) && !tok_in.done &&
                    (!valid || ((length == tok_in.len) && (prefix == tok_in.key)));

  // Take over the best match only when strictly longer, so the lowest slot wins ties.
  assign take_lookup = tok_in.valid && (tok_in.kind == lprl_pkg::KIND_LOOKUP) && valid &&
                       ((tok_in.key & lprl_pkg::len_mask(length)) == prefix) &&
                       (!tok_in.done || (length > tok_in.len));

  always_comb begin
    tok_next = tok_in;
    if (take_add) begin
      tok_next.done = 1'b1;
    end
    if (take_lookup) begin
      tok_next.done    = 1'b1;
      tok_next.len     = length;
      tok_next.iface   = iface;
      tok_next.has_hop = has_hop;
      tok_next.hop     = hop;
    end
  end

  // Hold the slot's valid bit and advance the request; clear both on reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= 1'b0;
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
      if (take_add) begin
        valid <= 1'b1;
      end
    end
  end

  // Write the route payload.
  always_ff @(posedge clk) begin
    if (take_add) begin
      prefix  <= tok_in.key;
      length  <= tok_in.len;
      iface   <= tok_in.iface;
      has_hop <= tok_in.has_hop;
      hop     <= tok_in.hop;
    end
  end

endmodule

### design/longest_prefix_route_lookup_unit.sv
// IPv4 longest-prefix-match route table: top level with the chain of slot cells.
// Depends on lprl_pkg and lprl_cell.
`timescale 1ns / 1ps

// The table is a row of TABLE_ENTRIES cells, one route per cell. Each request
// (add or lookup) enters the first cell and moves one cell per clock; an add
// is written into the first cell that holds the same route or is free, and a
// lookup picks up the longest matching route on its way. One request is in the
// chain at a time: the next one is accepted only once the current one has left
// the last cell of the row and no result waits in the skid register.
// Results land in an output register backed by one skid register, so a
// stalled consumer does not stop the chain. No clearing pass after reset.
module longest_prefix_route_lookup_unit #(
  parameter int TABLE_ENTRIES  = 32,
  parameter int INTERFACE_BITS = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // [31:0] net_prefix, [37:32] prefix_bits, [41:38] out_interface,
  // [42] hop_present, [74:43] hop_address, [106:75] dest_address
  input  logic [111:0]  s_tdata,
  // [0] kind
  input  logic          s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // [3:0] chosen_interface, [35:4] forward_address, [41:36] matched_bits
  output logic [47:0]   m_tdata,
  // [1:0] status
  output logic [1:0]    m_tuser
);

  localparam int IFW = lprl_pkg::IFACE_BITS;
  localparam int AW  = lprl_pkg::ADDR_BITS;
  localparam int LW  = lprl_pkg::LEN_BITS;
  localparam logic [IFW-1:0] IFACE_MASK =
    (INTERFACE_BITS >= IFW) ? {IFW{1'b1}} : IFW'((1 << INTERFACE_BITS) - 1);

  lprl_pkg::token_t chain [TABLE_ENTRIES+1];
  lprl_pkg::token_t last;

  logic            busy;
  logic            accept;
  logic            out_free;
  logic            skid_valid;
  logic [47:0]     skid_data;
  logic [1:0]      skid_user;
  logic [47:0]     res_data;
  lprl_pkg::status_t res_status;

  logic [AW-1:0]   in_prefix;
  logic [LW-1:0]   in_bits;
  logic [LW-1:0]   in_len;
  logic [IFW-1:0]  in_iface;
  logic            in_has_hop;
  logic [AW-1:0]   in_hop;
  logic [AW-1:0]   in_dest;

  assign s_tready = !rst && !busy && !skid_valid;
  assign accept   = s_tvalid && s_tready;

  // Unpack the request and clamp, mask and normalize the route fields.
  assign in_prefix  = s_tdata[31:0];
  assign in_bits    = s_tdata[37:32];
  assign in_iface   = s_tdata[41:38] & IFACE_MASK;
  assign in_has_hop = s_tdata[42];
  assign in_hop     = s_tdata[74:43];
  assign in_dest    = s_tdata[106:75];
  assign in_len     = (in_bits > LW'(AW)) ? LW'(AW) : in_bits;

  always_comb begin
    chain[0].valid = accept;
    chain[0].kind  = lprl_pkg::kind_t'(s_tuser);
    chain[0].done  = 1'b0;
    if (lprl_pkg::kind_t'(s_tuser) == lprl_pkg::KIND_ADD) begin
      chain[0].key     = in_prefix & lprl_pkg::len_mask(in_len);
      chain[0].len     = in_len;
      chain[0].iface   = in_iface;
      chain[0].has_hop = in_has_hop;
      chain[0].hop     = in_has_hop ? in_hop : '0;
    end else begin
      chain[0].key     = in_dest;
      chain[0].len     = '0;
      chain[0].iface   = '0;
      chain[0].has_hop = 1'b0;
      chain[0].hop     = '0;
    end
  end

  // Row of table cells.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    lprl_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  assign last = chain[TABLE_ENTRIES];

  // Form the result from the request leaving the last cell.
  always_comb begin
    res_data = '0;
    if (last.kind == lprl_pkg::KIND_ADD) begin
      res_status = last.done ? lprl_pkg::ST_ADDED : lprl_pkg::ST_FULL;
    end else if (last.done) begin
      res_status     = lprl_pkg::ST_HIT;
      res_data[3:0]  = last.iface;
      res_data[35:4] = last.has_hop ? last.hop : last.key;
      res_data[41:36] = last.len;
    end else begin
      res_status = lprl_pkg::ST_MISS;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  // Track the request in flight and drive the output and skid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (last.valid) begin
        busy <= 1'b0;
      end
      if (out_free) begin
        if (skid_valid) begin
          m_tvalid   <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          m_tvalid <= last.valid;
        end
      end else if (last.valid) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= res_data;
        m_tuser <= res_status;
      end
    end else if (last.valid) begin
      skid_data <= res_data;
      skid_user <= res_status;
    end
  end

endmodule

### dv/tb.sv
// Testbench for longest_prefix_route_lookup_unit: route adds and address lookups
// over the stream ports, checked against a shadow route table. Depends on lprl_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int ROUTE_SLOTS     = 32;
  localparam int IFACE_WIDTH_CFG = 4;
  localparam int RANDOM_ITEMS    = 1430;
  localparam int EARLY_ROUTE_CAP = 28;
  localparam int WATCHDOG_CYCLES = 4000;
  localparam int REPORT_LIMIT    = 10;

  typedef struct packed {
    lprl_pkg::kind_t kind;
    logic [31:0] net_prefix;
    logic [5:0]  prefix_bits;
    logic [3:0]  out_interface;
    logic        hop_present;
    logic [31:0] hop_address;
    logic [31:0] dest_address;
  } route_request_t;

  typedef struct packed {
    lprl_pkg::status_t status;
    logic [3:0]  iface;
    logic [31:0] fwd_addr;
    logic [5:0]  matched_len;
  } route_reply_t;

  // Shadow route table plus the queue of replies it predicts.
  class route_shadow;
    bit          slot_valid[ROUTE_SLOTS];
    logic [31:0] slot_prefix[ROUTE_SLOTS];
    logic [5:0]  slot_len[ROUTE_SLOTS];
    logic [3:0]  slot_iface[ROUTE_SLOTS];
    bit          slot_has_hop[ROUTE_SLOTS];
    logic [31:0] slot_hop[ROUTE_SLOTS];
    route_reply_t expected_replies[$];
    int failures;

    function new();
      failures = 0;
      foreach (slot_valid[i]) slot_valid[i] = 1'b0;
    endfunction

    // Leading-ones mask for a prefix length of 0 to 32.
    function logic [31:0] span_mask(int n);
      if (n <= 0) return 32'h0;
      return 32'hFFFF_FFFF << (32 - n);
    endfunction

    function int routes_held();
      int n;
      n = 0;
      foreach (slot_valid[i]) if (slot_valid[i]) n++;
      return n;
    endfunction

    // Return a random installed slot, or -1 when the table is empty.
    function int pick_route();
      int held[$];
      foreach (slot_valid[i]) if (slot_valid[i]) held.push_back(i);
      if (held.size() == 0) return -1;
      return held[$urandom_range(0, held.size() - 1)];
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void flag(string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Apply one accepted request to the shadow table and queue its reply.
    function void note_request(route_request_t req);
      route_reply_t exp;
      int len;
      int hit;
      int free_slot;
      int best;
      logic [31:0] key;
      exp = '0;
      if (req.kind == lprl_pkg::KIND_ADD) begin
        len = (req.prefix_bits > 6'd32) ? 32 : int'(req.prefix_bits);
        key = req.net_prefix & span_mask(len);
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
          if (slot_valid[i]) begin
            if (hit < 0 && int'(slot_len[i]) == len && slot_prefix[i] == key) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit < 0) hit = free_slot;
        if (hit < 0) begin
          exp.status = lprl_pkg::ST_FULL;
        end else begin
          slot_valid[hit]   = 1'b1;
          slot_prefix[hit]  = key;
          slot_len[hit]     = 6'(len);
          slot_iface[hit]   = req.out_interface & 4'((1 << IFACE_WIDTH_CFG) - 1);
          slot_has_hop[hit] = req.hop_present;
          slot_hop[hit]     = req.hop_present ? req.hop_address : 32'h0;
          exp.status = lprl_pkg::ST_ADDED;
        end
      end else begin
        best = -1;
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
          if (slot_valid[i] && (req.dest_address & span_mask(slot_len[i])) == slot_prefix[i])
            if (best < 0 || slot_len[i] > slot_len[best]) best = i;
        end
        if (best < 0) begin
          exp.status = lprl_pkg::ST_MISS;
        end else begin
          exp.status      = lprl_pkg::ST_HIT;
          exp.iface       = slot_iface[best];
          exp.fwd_addr    = slot_has_hop[best] ? slot_hop[best] : req.dest_address;
          exp.matched_len = slot_len[best];
        end
      end
      expected_replies.push_back(exp);
    endfunction

    // Compare one accepted reply with the oldest prediction, field by field.
    function void check_reply(route_reply_t got);
      route_reply_t exp;
      if (expected_replies.size() == 0) begin
        flag($sformatf("unexpected reply status=%0d iface=%h hop=%h len=%0d",
                       got.status, got.iface, got.fwd_addr, got.matched_len));
        return;
      end
      exp = expected_replies.pop_front();
      if (got.status !== exp.status)
        flag($sformatf("status expected %0d got %0d", exp.status, got.status));
      if (got.iface !== exp.iface)
        flag($sformatf("interface expected %h got %h", exp.iface, got.iface));
      if (got.fwd_addr !== exp.fwd_addr)
        flag($sformatf("forward address expected %h got %h", exp.fwd_addr, got.fwd_addr));
      if (got.matched_len !== exp.matched_len)
        flag($sformatf("matched bits expected %0d got %0d", exp.matched_len,
                       got.matched_len));
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [47:0]  m_tdata;
  logic [1:0]   m_tuser;

  route_shadow sb = new();
  int burst_left = 0;
  int idle_cycles = 0;
  int recv_cycle = 0;
  int recv_mode = 0;

  longest_prefix_route_lookup_unit #(
    .TABLE_ENTRIES (ROUTE_SLOTS),
    .INTERFACE_BITS(IFACE_WIDTH_CFG)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the reply side on a ready pattern drawn at random from four modes.
  always @(posedge clk) begin
    recv_cycle <= recv_cycle + 1;
    if (recv_cycle % 256 == 0) recv_mode <= $urandom_range(0, 3);
    case (recv_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= (recv_cycle % 7) < 3;
      default: m_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Check every accepted reply.
  always @(posedge clk) begin
    route_reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status      = lprl_pkg::status_t'(m_tuser);
      got.iface       = m_tdata[3:0];
      got.fwd_addr    = m_tdata[35:4];
      got.matched_len = m_tdata[41:36];
      sb.check_reply(got);
    end
  end

  // End the run when neither side has moved for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Present one request in bursts with random gaps, then record it once accepted.
  task automatic send_request(input route_request_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {5'b0, r.dest_address, r.hop_address, r.hop_present, r.out_interface,
                 r.prefix_bits, r.net_prefix};
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
  endtask

  // Unused fields of each request carry random noise.
  task automatic issue_add(input logic [31:0] pfx, input logic [5:0] bits,
                           input logic [3:0] iface, input logic has_hop,
                           input logic [31:0] hop);
    route_request_t r;
    r.kind          = lprl_pkg::KIND_ADD;
    r.net_prefix    = pfx;
    r.prefix_bits   = bits;
    r.out_interface = iface;
    r.hop_present   = has_hop;
    r.hop_address   = hop;
    r.dest_address  = $urandom;
    send_request(r);
  endtask

  task automatic issue_lookup(input logic [31:0] dest);
    route_request_t r;
    r.kind          = lprl_pkg::KIND_LOOKUP;
    r.net_prefix    = $urandom;
    r.prefix_bits   = 6'($urandom_range(0, 63));
    r.out_interface = 4'($urandom);
    r.hop_present   = 1'($urandom);
    r.hop_address   = $urandom;
    r.dest_address  = dest;
    send_request(r);
  endtask

  // Add a route: overwrite a held one, nest under one, or start a new one.
  task automatic random_add(input bit early, inout bit default_sent);
    int s;
    int sel;
    int len;
    logic [31:0] m;
    logic [5:0] bits;
    logic [31:0] pfx;
    s = sb.pick_route();
    sel = $urandom_range(0, 19);
    if (!early && !default_sent) begin
      default_sent = 1'b1;
      bits = 6'd0;
      pfx  = $urandom;
    end else if (s >= 0 && (sel < 8 || (early && sb.routes_held() >= EARLY_ROUTE_CAP))) begin
      // overwrite with stray bits past the length
      m    = sb.span_mask(sb.slot_len[s]);
      pfx  = sb.slot_prefix[s] | ($urandom & ~m);
      bits = (sb.slot_len[s] == 6'd32) ? 6'($urandom_range(32, 63)) : sb.slot_len[s];
    end else if (s >= 0 && sel < 12) begin
      // nest an equal or longer route under a held one
      len  = $urandom_range(sb.slot_len[s], 32);
      pfx  = sb.slot_prefix[s] | ($urandom & ~sb.span_mask(sb.slot_len[s]));
      bits = 6'(len);
    end else begin
      pfx = $urandom;
      if (sel < 16)      bits = 6'($urandom_range(16, 32));
      else if (sel < 18) bits = 6'($urandom_range(1, 15));
      else if (sel < 19 || early) bits = 6'($urandom_range(33, 63));
      else               bits = 6'd0;
    end
    issue_add(pfx, bits, 4'($urandom), 1'($urandom), $urandom);
  endtask

  // Look up an address under a held route most of the time.
  task automatic random_lookup();
    int s;
    int sel;
    logic [31:0] m;
    logic [31:0] dest;
    s = sb.pick_route();
    sel = $urandom_range(0, 19);
    if (sel == 0)      dest = 32'h0;
    else if (sel == 1) dest = 32'hFFFF_FFFF;
    else if (s >= 0 && sel < 16) begin
      m    = sb.span_mask(sb.slot_len[s]);
      dest = (sb.slot_prefix[s] & m) | ($urandom & ~m);
    end else begin
      dest = $urandom;
    end
    issue_lookup(dest);
  endtask

  initial begin
    bit default_sent;
    bit early;
    default_sent = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: misses on an empty table, nested routes, saturated and
    // over-long lengths, direct versus next-hop forwarding, overwrite.
    issue_lookup(32'h0000_0000);
    issue_lookup(32'hFFFF_FFFF);
    issue_add(32'h0A00_0000, 6'd8, 4'd1, 1'b0, 32'hDEAD_BEEF);
    issue_add(32'h0A01_FFFF, 6'd16, 4'd2, 1'b1, 32'hC0A8_0001);
    issue_add(32'h0A01_0203, 6'd32, 4'd15, 1'b1, 32'hFFFF_FFFF);
    issue_add(32'h0A01_0204, 6'd63, 4'd0, 1'b0, 32'h1234_5678);
    issue_add(32'h0A01_0205, 6'd33, 4'd3, 1'b1, 32'h0000_0000);
    issue_lookup(32'h0A01_0203);
    issue_lookup(32'h0A01_0204);
    issue_lookup(32'h0A01_0205);
    issue_lookup(32'h0A01_0909);
    issue_lookup(32'h0AC8_0001);
    issue_lookup(32'h0B00_0000);
    issue_add(32'h0A01_4D00, 6'd16, 4'd4, 1'b0, 32'hAAAA_5555);
    issue_lookup(32'h0A01_0303);
    issue_add(32'hFFFF_FFFF, 6'd1, 4'd5, 1'b1, 32'h1234_5678);
    issue_lookup(32'h8000_0000);
    issue_lookup(32'h7FFF_FFFF);
    issue_add(32'h0000_0000, 6'd32, 4'd6, 1'b1, 32'h5555_AAAA);
    issue_lookup(32'h0000_0000);

    // Random: no default route in the first half so misses stay possible,
    // then the default route and enough new routes to fill the table.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      early = (i < RANDOM_ITEMS / 2);
      if ($urandom_range(0, 99) < 45) random_lookup();
      else random_add(early, default_sent);
    end
    s_tvalid <= 1'b0;

    // Drain, then allow time for any stray reply.
    while (sb.pending() != 0) @(posedge clk);
    repeat (3 * ROUTE_SLOTS) @(posedge clk);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
design/lprl_pkg.sv
design/lprl_cell.sv
design/longest_prefix_route_lookup_unit.sv
dv/tb.sv
